// ===== hw/rtl/quantized_dot_product_requant_assert.svh =====
// assertion macros for the requant block
`ifndef QUANTIZED_DOT_PRODUCT_REQUANT_ASSERT_SVH
`define QUANTIZED_DOT_PRODUCT_REQUANT_ASSERT_SVH

// checked only outside reset
`define QDPR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define QDPR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/qdpr_pkg.sv =====
`timescale 1ns / 1ps

package qdpr_pkg;

   localparam int LANES     = 4;
   localparam int ACT_W     = 8;
   localparam int WT_W      = 8;
   localparam int ACC_W     = 32;
   localparam int SHIFT_W   = 5;
   localparam int OUT_W     = 8;
   localparam int PROD_W    = ACT_W + WT_W + 1;
   localparam int GSUM_W    = PROD_W + $clog2(LANES);
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   typedef struct packed {
      logic [GSUM_W-1:0] group_sum;
      logic [ACC_W-1:0]  scale;
      logic [ACC_W-1:0]  offset;
      logic              last;
   } mid_word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

// ===== hw/rtl/qdpr_fifo.sv =====
`timescale 1ns / 1ps

module qdpr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output qdpr_pkg::fifo_status_type  status,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign count        = count_ff;

endmodule

// ===== hw/rtl/qdpr_front.sv =====
`timescale 1ns / 1ps

module qdpr_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic [qdpr_pkg::ACT_W-1:0]           act [qdpr_pkg::LANES],
   input  logic signed [qdpr_pkg::WT_W-1:0]     wt [qdpr_pkg::LANES],
   input  logic [qdpr_pkg::ACC_W-1:0]           scale,
   input  logic [qdpr_pkg::ACC_W-1:0]           offset,
   input  logic                                 last,
   input  qdpr_pkg::fifo_status_type            mid_status,
   output logic                                 mid_push,
   output qdpr_pkg::mid_word_type               mid_word
);

   logic                                  valid_ff, valid_in;
   qdpr_pkg::mid_word_type                word_ff;
   logic                                  accept;
   logic signed [qdpr_pkg::PROD_W-1:0]    prod [qdpr_pkg::LANES];
   logic signed [qdpr_pkg::GSUM_W-1:0]    gsum;

   always_comb begin
      for (int i = 0; i < qdpr_pkg::LANES; i++) begin
         prod[i] = $signed({1'b0, act[i]}) * wt[i];
      end
   end

   always_comb begin
      gsum = '0;
      for (int i = 0; i < qdpr_pkg::LANES; i++) begin
         gsum = gsum + qdpr_pkg::GSUM_W'(prod[i]);
      end
   end

   assign full     = valid_ff && mid_status.full;
   assign accept   = push && !full;
   assign mid_push = valid_ff && !mid_status.full;
   assign valid_in = accept || (valid_ff && mid_status.full);
   assign mid_word = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff.group_sum <= gsum;
         word_ff.scale     <= scale;
         word_ff.offset    <= offset;
         word_ff.last      <= last;
      end
   end

endmodule

// ===== hw/rtl/qdpr_back.sv =====
`timescale 1ns / 1ps

module qdpr_back #(
   parameter int OUT_DEPTH = qdpr_pkg::OUT_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [qdpr_pkg::SHIFT_W-1:0]       csr_wr_data,
   input  qdpr_pkg::mid_word_type             mid_word,
   input  qdpr_pkg::fifo_status_type          mid_status,
   output logic                               mid_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
   output logic                               out_push,
   output logic [qdpr_pkg::OUT_W-1:0]         out_data
);

   localparam int ACC_W = qdpr_pkg::ACC_W;
   localparam int CRW   = $clog2(OUT_DEPTH + 3);

   logic [qdpr_pkg::SHIFT_W-1:0] shift_ff;
   logic [ACC_W-1:0]             acc_ff, acc_in;
   logic [ACC_W-1:0]             sum;
   logic                         s1_valid_ff, s2_valid_ff;
   logic [ACC_W-1:0]             s1_sum_ff, s1_scale_ff, s1_offset_ff;
   logic [ACC_W-1:0]             s2_prod_ff, s2_offset_ff;
   logic [2*ACC_W-1:0]           full_prod;
   logic [CRW-1:0]               inflight;
   logic signed [ACC_W-1:0]      biased, shifted;

   // reserve a result slot for every last word in flight
   assign inflight = CRW'(out_count) + CRW'(s1_valid_ff) + CRW'(s2_valid_ff);
   assign mid_pop  = !mid_status.empty && (inflight < CRW'(OUT_DEPTH));

   assign sum = acc_ff + ACC_W'($signed(mid_word.group_sum));

   always_comb begin
      acc_in = acc_ff;
      if (mid_pop) begin
         acc_in = mid_word.last ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff    <= '0;
         acc_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            shift_ff <= csr_wr_data;
         end
         acc_ff      <= acc_in;
         s1_valid_ff <= mid_pop && mid_word.last;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   assign full_prod = s1_scale_ff * s1_sum_ff;

   always_ff @(posedge clock) begin
      if (mid_pop && mid_word.last) begin
         s1_sum_ff    <= sum;
         s1_scale_ff  <= mid_word.scale;
         s1_offset_ff <= mid_word.offset;
      end
      if (s1_valid_ff) begin
         s2_prod_ff   <= full_prod[ACC_W-1:0];
         s2_offset_ff <= s1_offset_ff;
      end
   end

   // offset, shift and clamp to a byte
   always_comb begin
      biased  = $signed(s2_prod_ff + s2_offset_ff);
      shifted = biased >>> shift_ff;
      if (shifted[ACC_W-1]) begin
         out_data = '0;
      end else if (|shifted[ACC_W-2:qdpr_pkg::OUT_W]) begin
         out_data = '1;
      end else begin
         out_data = shifted[qdpr_pkg::OUT_W-1:0];
      end
   end

   assign out_push = s2_valid_ff;

endmodule

// ===== hw/rtl/quantized_dot_product_requant.sv =====
`timescale 1ns / 1ps
// quantized dot product with requantization
// input queue: drive the req_ ports and raise req_push; a word is taken at an
// edge where req_push is high and req_full is low, one word per cycle at most
// each word adds four activation by weight products into a wrapping 32-bit sum
// a word with req_last_group set closes the sum: scale, offset, arithmetic
// shift by the csr value, clamp to 0..255, one byte out, sum cleared
// result queue: rsp_out_byte is valid while rsp_empty is low, taken with rsp_pop
// a last word reaches the result side through the front register, the group queue,
// accumulate, multiply and clamp into the result queue; full queues can hold it
// throughput: one word per cycle unless the queues hold it, set by the combinational
// lane adder and the accumulate stage; results leave at one per cycle
// csr_wr_en writes the shift at once; write it only while the block is idle
// when the receiver stalls the result queue fills, the back end stops taking
// groups once every result slot is claimed, and req_full rises after the group
// queue and front register fill
// reset clears the sum, the shift and both queues; no clearing pass

module quantized_dot_product_requant #(
   parameter int MID_DEPTH = qdpr_pkg::MID_DEPTH,
   parameter int OUT_DEPTH = qdpr_pkg::OUT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [qdpr_pkg::ACT_W-1:0]          req_act_lane0,
   input  logic [qdpr_pkg::ACT_W-1:0]          req_act_lane1,
   input  logic [qdpr_pkg::ACT_W-1:0]          req_act_lane2,
   input  logic [qdpr_pkg::ACT_W-1:0]          req_act_lane3,
   input  logic signed [qdpr_pkg::WT_W-1:0]    req_wt_lane0,
   input  logic signed [qdpr_pkg::WT_W-1:0]    req_wt_lane1,
   input  logic signed [qdpr_pkg::WT_W-1:0]    req_wt_lane2,
   input  logic signed [qdpr_pkg::WT_W-1:0]    req_wt_lane3,
   input  logic signed [qdpr_pkg::ACC_W-1:0]   req_chan_scale,
   input  logic signed [qdpr_pkg::ACC_W-1:0]   req_chan_offset,
   input  logic                                req_last_group,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [qdpr_pkg::OUT_W-1:0]          rsp_out_byte,
   input  logic                                csr_wr_en,
   input  logic [qdpr_pkg::SHIFT_W-1:0]        csr_wr_data
);

   logic [qdpr_pkg::ACT_W-1:0]        act [qdpr_pkg::LANES];
   logic signed [qdpr_pkg::WT_W-1:0]  wt [qdpr_pkg::LANES];
   qdpr_pkg::mid_word_type            front_word, mid_word;
   qdpr_pkg::fifo_status_type         mid_status, out_status;
   logic                              mid_push, mid_pop;
   logic [$clog2(MID_DEPTH+1)-1:0]    mid_count;
   logic [$clog2(OUT_DEPTH+1)-1:0]    out_count;
   logic                              out_push;
   logic [qdpr_pkg::OUT_W-1:0]        out_data;

   assign act[0] = req_act_lane0;
   assign act[1] = req_act_lane1;
   assign act[2] = req_act_lane2;
   assign act[3] = req_act_lane3;
   assign wt[0]  = req_wt_lane0;
   assign wt[1]  = req_wt_lane1;
   assign wt[2]  = req_wt_lane2;
   assign wt[3]  = req_wt_lane3;

   qdpr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .act        (act),
      .wt         (wt),
      .scale      (req_chan_scale),
      .offset     (req_chan_offset),
      .last       (req_last_group),
      .mid_status (mid_status),
      .mid_push   (mid_push),
      .mid_word   (front_word)
   );

   qdpr_fifo #(
      .WIDTH ($bits(qdpr_pkg::mid_word_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (front_word),
      .pop       (mid_pop),
      .pop_data  (mid_word),
      .status    (mid_status),
      .count     (mid_count)
   );

   qdpr_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mid_word    (mid_word),
      .mid_status  (mid_status),
      .mid_pop     (mid_pop),
      .out_count   (out_count),
      .out_push    (out_push),
      .out_data    (out_data)
   );

   qdpr_fifo #(
      .WIDTH (qdpr_pkg::OUT_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .pop       (rsp_pop && !out_status.empty),
      .pop_data  (rsp_out_byte),
      .status    (out_status),
      .count     (out_count)
   );

   assign rsp_empty = out_status.empty || (mid_count > MID_DEPTH[$clog2(MID_DEPTH+1)-1:0]);

endmodule

// ===== hw/rtl/qdpr_checker.sv =====
`timescale 1ns / 1ps
`include "quantized_dot_product_requant_assert.svh"

module qdpr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_push,
   input logic                         req_full,
   input logic                         req_last_group,
   input logic                         rsp_empty,
   input logic                         rsp_pop,
   input logic [qdpr_pkg::OUT_W-1:0]   rsp_out_byte
);

   logic [7:0] pending_ff, pending_in;
   logic       last_in, word_out;

   // last words taken whose byte is not yet popped
   assign last_in  = req_push && !req_full && req_last_group;
   assign word_out = rsp_pop && !rsp_empty;

   always_comb begin
      pending_in = pending_ff + 8'(last_in) - 8'(word_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `QDPR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty, "result queue not empty after reset")
   `QDPR_ASSERT_ALWAYS(a_reset_ready, clock, reset |=> !req_full, "input full after reset")
   `QDPR_ASSERT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_out_byte), "stalled result changed")
   `QDPR_ASSERT(a_rsp_owed, clock, reset, !rsp_empty |-> pending_ff != 8'd0, "result without a last word")

endmodule

bind quantized_dot_product_requant qdpr_checker u_qdpr_checker (.*);
